[hdl/imu_cf_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// imu_cf_pkg
// Shared types, constants and tables of the IMU complementary filter.
// ============================================================================
package imu_cf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int MUL_A_W          = 48;
    localparam int MUL_BITS         = 34;
    localparam int ACC_W            = MUL_A_W + MUL_BITS;
    localparam int SQRT_STEPS       = 26;
    localparam int SQRT_TOP         = 2 * (SQRT_STEPS - 1);
    localparam int CNT_W            = 6;
    localparam int CORD_W           = 34;
    localparam int ANG_W            = 26;

    localparam logic signed [23:0] ANGLE_LIMIT  = 24'sd5898240;
    localparam logic [CORD_W-1:0]  INV_GAIN_Q30 = CORD_W'(652032874);

    localparam logic [15:0] BLEND_RESET = 16'd16384;
    localparam logic [15:0] STEP_RESET  = 16'd655;
    localparam logic [15:0] DRIFT_RESET = 16'd229;

    localparam logic [7:0] REG_BLEND_WEIGHT = 8'd0;
    localparam logic [7:0] REG_STEP_TIME    = 8'd1;
    localparam logic [7:0] REG_YAW_DRIFT    = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_MUL,
        PH_SQRT,
        PH_CORD,
        PH_STORE,
        PH_FINISH
    } phase_t;

    typedef enum logic [4:0] {
        ST_SIN_P,
        ST_SIN_R,
        ST_MUL_SS,
        ST_MUL_CS,
        ST_MUL_ZC,
        ST_MUL_YT,
        ST_MUL_XT,
        ST_MUL_INC,
        ST_MUL_PDT,
        ST_MUL_RDT,
        ST_MUL_AY,
        ST_MUL_AZ1,
        ST_SQRT_P,
        ST_VEC_P,
        ST_MUL_AX,
        ST_MUL_AZ2,
        ST_SQRT_R,
        ST_VEC_R,
        ST_MUL_PW,
        ST_MUL_PA,
        ST_MUL_RW,
        ST_MUL_RA
    } step_t;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        logic [22:0] v;
        case (i)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // clamp a blended angle to +-90 degrees
    function automatic logic signed [23:0] sat_angle(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v > 34'(ANGLE_LIMIT)) begin
            r = ANGLE_LIMIT;
        end else if (v < -34'(ANGLE_LIMIT)) begin
            r = -ANGLE_LIMIT;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

[hdl/imu_complementary_filter.sv]
`timescale 1ns / 1ps
// ============================================================================
// imu_complementary_filter
// Pitch, roll and yaw estimation from one accel + gyro item per update.
// ============================================================================
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, accel_xyz, gyro_xyz   | sink
//  out     | out_valid/out_ready, pitch/roll/yaw      | source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | sink
//
//  One item takes 22 sequencer steps: 16 shift-add multiplies of
//  MUL_BITS (34) bits each, two square roots and four CORDIC runs,
//  each step framed by a setup and a store state, plus a finish state
//  and an accept state. All multiplies share the one bit-serial
//  multiplier.
//  Reset clears the angles and loads the register defaults.
//  A new item is taken while the previous result still waits on out; the
//  final update holds until that result is taken. cfg is always ready.
//
module imu_complementary_filter #(
    parameter int CORDIC_STEPS = imu_cf_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] pitch_angle,
    output logic signed [23:0] roll_angle,
    output logic signed [31:0] yaw_angle,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import imu_cf_pkg::*;

    // control
    phase_t             phase_reg, phase_next;
    step_t              step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;

    // registers and filter state
    logic [15:0]        blend_reg, dt_reg, drift_reg;
    logic signed [23:0] pitch_reg, roll_reg;
    logic [31:0]        yaw_reg;

    // captured item
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;

    // multiplier
    logic signed [ACC_W-1:0]    acc_reg, mcand_reg, pp;
    logic [MUL_BITS-1:0]        mplier_reg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [MUL_BITS-1:0]        mul_b;
    logic                       mul_clr;
    logic [16:0]                acc_weight;

    // square root
    logic [47:0]                sq_n_reg;
    logic [50:0]                sq_r_reg, sq_bit;
    logic [51:0]                sq_trial;
    logic [CNT_W-1:0]           sq_sh;

    // cordic
    logic signed [CORD_W-1:0]   cx_reg, cy_reg, cdx, cdy;
    logic signed [ANG_W-1:0]    cz_reg, c_at;
    logic                       cvec_reg, c_neg;
    logic [4:0]                 c_idx;

    // intermediates
    logic signed [CORD_W-1:0]   sp_reg, cp_reg, sr_reg, cr_reg, t1_reg, t2_reg;
    logic signed [47:0]         rate_reg;
    logic [31:0]                inc_reg;
    logic signed [33:0]         candp_reg, candr_reg;
    logic signed [ANG_W-1:0]    accp_reg, accr_reg;
    logic signed [23:0]         pnew_reg, rnew_reg;

    logic unit_done, out_free;

    assign in_ready    = (phase_reg == PH_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign yaw_angle   = yaw_reg;
    assign out_free    = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Phase sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        case (phase_reg)
            PH_MUL:  unit_done = (cnt_reg == CNT_W'(MUL_BITS - 1));
            PH_SQRT: unit_done = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
            PH_CORD: unit_done = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
            default: unit_done = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid) phase_next = PH_SETUP;
            end
            PH_SETUP:
            begin
                case (step_reg)
                    ST_SIN_P, ST_SIN_R, ST_VEC_P, ST_VEC_R: phase_next = PH_CORD;
                    ST_SQRT_P, ST_SQRT_R:                   phase_next = PH_SQRT;
                    default:                                phase_next = PH_MUL;
                endcase
            end
            PH_MUL, PH_SQRT, PH_CORD:
            begin
                if (unit_done) phase_next = PH_STORE;
            end
            PH_STORE:
            begin
                phase_next = (step_reg == ST_MUL_RA) ? PH_FINISH : PH_SETUP;
            end
            PH_FINISH:
            begin
                if (out_free) phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Operand selection per step
    // ------------------------------------------------------------------
    assign acc_weight = 17'h10000 - {1'b0, blend_reg};

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_clr = 1'b1;
        case (step_reg)
            ST_MUL_SS:  begin mul_a = MUL_A_W'(sr_reg); mul_b = sp_reg; end
            ST_MUL_CS:  begin mul_a = MUL_A_W'(cr_reg); mul_b = sp_reg; end
            ST_MUL_ZC:  begin mul_a = MUL_A_W'(gz_reg); mul_b = cp_reg; end
            ST_MUL_YT:
            begin
                mul_a   = -MUL_A_W'(gy_reg);
                mul_b   = t1_reg;
                mul_clr = 1'b0;
            end
            ST_MUL_XT:
            begin
                mul_a   = MUL_A_W'(gx_reg);
                mul_b   = t2_reg;
                mul_clr = 1'b0;
            end
            ST_MUL_INC:
            begin
                mul_a = MUL_A_W'(rate_reg >>> 6);
                mul_b = {18'd0, dt_reg};
            end
            ST_MUL_PDT: begin mul_a = MUL_A_W'(gx_reg); mul_b = {18'd0, dt_reg}; end
            ST_MUL_RDT: begin mul_a = MUL_A_W'(gy_reg); mul_b = {18'd0, dt_reg}; end
            ST_MUL_AY:  begin mul_a = MUL_A_W'(ay_reg); mul_b = MUL_BITS'(ay_reg); end
            ST_MUL_AX:  begin mul_a = MUL_A_W'(ax_reg); mul_b = MUL_BITS'(ax_reg); end
            ST_MUL_AZ1, ST_MUL_AZ2:
            begin
                mul_a   = MUL_A_W'(az_reg);
                mul_b   = MUL_BITS'(az_reg);
                mul_clr = 1'b0;
            end
            ST_MUL_PW:  begin mul_a = MUL_A_W'(candp_reg); mul_b = {18'd0, blend_reg}; end
            ST_MUL_RW:  begin mul_a = MUL_A_W'(candr_reg); mul_b = {18'd0, blend_reg}; end
            ST_MUL_PA:
            begin
                mul_a   = MUL_A_W'(accp_reg);
                mul_b   = {17'd0, acc_weight};
                mul_clr = 1'b0;
            end
            ST_MUL_RA:
            begin
                mul_a   = MUL_A_W'(accr_reg);
                mul_b   = {17'd0, acc_weight};
                mul_clr = 1'b0;
            end
            default: mul_clr = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Arithmetic units, one bit / one digit / one rotation per cycle
    // ------------------------------------------------------------------
    // add the multiplicand for a set multiplier bit; the sign bit subtracts
    assign pp = mplier_reg[0] ? mcand_reg : '0;

    // root bit walks down two places per cycle
    assign sq_sh    = CNT_W'(SQRT_TOP) - {cnt_reg[CNT_W-2:0], 1'b0};
    assign sq_bit   = 51'd1 << sq_sh;
    assign sq_trial = 52'(sq_r_reg) + 52'(sq_bit);

    assign c_idx = cnt_reg[4:0];
    assign cdx   = cx_reg >>> c_idx;
    assign cdy   = cy_reg >>> c_idx;
    assign c_at  = ANG_W'(atan_deg(c_idx));
    // vectoring drives y to zero, rotation drives z to zero
    assign c_neg = cvec_reg ? (cy_reg > 0) : cz_reg[ANG_W-1];

    // ------------------------------------------------------------------
    // Control registers, configuration and filter state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            step_reg      <= ST_SIN_P;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            blend_reg     <= BLEND_RESET;
            dt_reg        <= STEP_RESET;
            drift_reg     <= DRIFT_RESET;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            yaw_reg       <= '0;
        end else begin
            phase_reg <= phase_next;

            if (cfg_valid) begin
                case (cfg_index)
                    REG_BLEND_WEIGHT: blend_reg <= cfg_data;
                    REG_STEP_TIME:    dt_reg    <= cfg_data;
                    REG_YAW_DRIFT:    drift_reg <= cfg_data;
                    default:          ;
                endcase
            end

            case (phase_reg)
                PH_IDLE:  step_reg <= ST_SIN_P;
                PH_SETUP: cnt_reg  <= '0;
                PH_MUL, PH_SQRT, PH_CORD: cnt_reg <= cnt_reg + 1'b1;
                PH_STORE:
                begin
                    if (step_reg != ST_MUL_RA) begin
                        step_reg <= step_t'(5'(step_reg) + 5'd1);
                    end
                end
                default: ;
            endcase

            // commit the new attitude once the previous result is gone
            if (phase_reg == PH_FINISH && out_free) begin
                pitch_reg     <= pnew_reg;
                roll_reg      <= rnew_reg;
                yaw_reg       <= yaw_reg + inc_reg - {16'd0, drift_reg};
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && in_valid) begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            gz_reg <= gyro_z;
        end

        case (phase_reg)
            PH_SETUP:
            begin
                mcand_reg  <= ACC_W'(mul_a);
                mplier_reg <= mul_b;
                if (mul_clr) acc_reg <= '0;
                sq_n_reg   <= {acc_reg[31:0], 16'd0};
                // keep the root through the vectoring step for the zero test
                if (step_reg == ST_SQRT_P || step_reg == ST_SQRT_R) begin
                    sq_r_reg <= '0;
                end
                case (step_reg)
                    ST_SIN_P, ST_SIN_R:
                    begin
                        cx_reg   <= INV_GAIN_Q30;
                        cy_reg   <= '0;
                        cz_reg   <= (step_reg == ST_SIN_P) ? ANG_W'(pitch_reg)
                                                           : ANG_W'(roll_reg);
                        cvec_reg <= 1'b0;
                    end
                    default:
                    begin
                        // magnitude in Q8 scaled by 64, numerator by 16384
                        cx_reg   <= {1'b0, sq_r_reg[26:0], 6'd0};
                        cy_reg   <= (step_reg == ST_VEC_P)
                                    ? {{4{ax_reg[15]}}, ax_reg, 14'd0}
                                    : {{4{ay_reg[15]}}, ay_reg, 14'd0};
                        cz_reg   <= '0;
                        cvec_reg <= 1'b1;
                    end
                endcase
            end
            PH_MUL:
            begin
                acc_reg    <= (cnt_reg == CNT_W'(MUL_BITS - 1)) ? acc_reg - pp
                                                                : acc_reg + pp;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            PH_SQRT:
            begin
                if (52'(sq_n_reg) >= sq_trial) begin
                    sq_n_reg <= sq_n_reg - sq_trial[47:0];
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
            end
            PH_CORD:
            begin
                if (c_neg) begin
                    cx_reg <= cx_reg + cdy;
                    cy_reg <= cy_reg - cdx;
                    cz_reg <= cz_reg + c_at;
                end else begin
                    cx_reg <= cx_reg - cdy;
                    cy_reg <= cy_reg + cdx;
                    cz_reg <= cz_reg - c_at;
                end
            end
            PH_STORE:
            begin
                case (step_reg)
                    ST_SIN_P:   begin sp_reg <= cy_reg; cp_reg <= cx_reg; end
                    ST_SIN_R:   begin sr_reg <= cy_reg; cr_reg <= cx_reg; end
                    ST_MUL_SS:  t1_reg <= acc_reg[63:30];
                    ST_MUL_CS:  t2_reg <= acc_reg[63:30];
                    ST_MUL_XT:  rate_reg <= acc_reg[47:0];
                    ST_MUL_INC: inc_reg <= acc_reg[61:30];
                    ST_MUL_PDT: candp_reg <= 34'(pitch_reg) + signed'(acc_reg[39:6]);
                    ST_MUL_RDT: candr_reg <= 34'(roll_reg) + signed'(acc_reg[39:6]);
                    // a zero accel vector gives a zero angle
                    ST_VEC_P:
                    begin
                        accp_reg <= (sq_r_reg == '0 && ax_reg == '0) ? '0 : cz_reg;
                    end
                    ST_VEC_R:
                    begin
                        accr_reg <= (sq_r_reg == '0 && ay_reg == '0) ? '0 : cz_reg;
                    end
                    ST_MUL_PA:  pnew_reg <= sat_angle(acc_reg[49:16]);
                    ST_MUL_RA:  rnew_reg <= sat_angle(acc_reg[49:16]);
                    default:    ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

[test/tb_imu_complementary_filter.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_imu_complementary_filter
// Self-checking bench for the IMU complementary filter.
// Drives accel/gyro items with random gaps, predicts pitch, roll and yaw with
// an in-bench fixed-point model, and checks every result in order.
// ============================================================================
module tb_imu_complementary_filter;
    import imu_cf_pkg::*;

    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int LIMIT      = 5898240;
    localparam int DOG_LIMIT  = 20000;
    localparam int SETTLE     = 2000;

    typedef struct {
        logic signed [23:0] pitch;
        logic signed [23:0] roll;
        logic signed [31:0] yaw;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] pitch_angle, roll_angle;
    logic signed [31:0] yaw_angle;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // predicted state and register copy
    longint    blend_w, dt, drift;
    longint    pitch_q, roll_q;
    logic [31:0] yaw_q;
    attitude_t attitude_queue[$];
    int        fail_count = 0;
    int        idle_cycles = 0;

    imu_complementary_filter uut (.*);

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 50;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint gravity_angle(longint num, longint a, longint b);
        longint x, y, z, dx, dy;
        x = isqrt(longint'(a * a + b * b) << 16) * 64;
        y = num * 16384;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(atan_deg(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_deg(5'(i)));
            end
        end
        return z;
    endfunction

    task automatic rotate(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = 652032874; y = 0; z = ang;
        for (int i = 0; i < STEPS; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_deg(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_deg(5'(i)));
            end
        end
        s = y;
        c = x;
    endtask

    function automatic longint mix_angle(longint prev, longint rate, longint acc);
        longint v;
        v = asr(blend_w * (prev + asr(rate * dt, 6)) + (65536 - blend_w) * acc, 16);
        if (v > LIMIT) v = LIMIT;
        if (v < -LIMIT) v = -LIMIT;
        return v;
    endfunction

    task automatic predict_attitude(input longint ax, ay, az, gx, gy, gz);
        longint sp, cp, sr, cr, rate, inc, pn, rn;
        attitude_t r;
        rotate(pitch_q, sp, cp);
        rotate(roll_q, sr, cr);
        rate = gz * cp - gy * asr(sr * sp, 30) + gx * asr(cr * sp, 30);
        inc = asr(asr(rate, 6) * dt, 30);
        pn = mix_angle(pitch_q, gx, gravity_angle(ax, ay, az));
        rn = mix_angle(roll_q, gy, gravity_angle(ay, ax, az));
        yaw_q = yaw_q + 32'(inc) - 32'(drift);
        pitch_q = pn;
        roll_q = rn;
        r.pitch = 24'(pn);
        r.roll = 24'(rn);
        r.yaw = yaw_q;
        attitude_queue.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // send one item after a random gap; hold it until the block takes it
    task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz);
        int gap;
        gap = $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= ax; accel_y <= ay; accel_z <= az;
        gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
        predict_attitude(longint'(signed'(ax)), longint'(signed'(ay)),
                         longint'(signed'(az)), longint'(signed'(gx)),
                         longint'(signed'(gy)), longint'(signed'(gz)));
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    // write one register; only called with nothing pending
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BLEND_WEIGHT) blend_w = val;
        else if (idx == REG_STEP_TIME) dt = val;
        else if (idx == REG_YAW_DRIFT) drift = val;
        @(posedge clk);
    endtask

    // drop the last item's valid, then wait for all results
    task automatic drain();
        in_valid <= 1'b0;
        wait (attitude_queue.size() == 0);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_defaults_directed();
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        drain();
    endtask

    // push angles into saturation with a full gyro weight and long step
    task automatic test_saturation_extremes();
        write_reg(REG_BLEND_WEIGHT, 16'hffff);
        write_reg(REG_STEP_TIME, 16'hffff);
        write_reg(REG_YAW_DRIFT, 16'hffff);
        for (int i = 0; i < 6; i++)
            send_sample(16'h7fff, 16'h8000, 16'h0001, 16'h7fff, 16'h8000, 16'h7fff);
        send_sample(16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'h8000);
        drain();
    endtask

    // accel-only blend and a frozen gyro; also odd register writes
    task automatic test_zero_weight_zero_step();
        write_reg(REG_BLEND_WEIGHT, 16'h0000);
        write_reg(REG_STEP_TIME, 16'h0000);
        write_reg(REG_YAW_DRIFT, 16'h0000);
        write_reg(8'hff, 16'h1234);
        write_reg(8'd3, 16'hffff);
        send_sample(16'h1000, 16'hf000, 16'h2000, 16'h7fff, 16'h8000, 16'h7fff);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h4321, 16'h8000);
        drain();
    endtask

    task automatic test_random_phase(input int count, input bit new_regs);
        if (new_regs) begin
            write_reg(REG_BLEND_WEIGHT, 16'($urandom));
            write_reg(REG_STEP_TIME, 16'($urandom_range(1, 65535)));
            write_reg(REG_YAW_DRIFT, 16'($urandom));
        end
        for (int i = 0; i < count; i++)
            send_sample(rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word(), rand_word());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (attitude_queue.size() == 0) begin
                $error("result with no item pending");
                fail_count++;
            end else begin
                attitude_t e;
                e = attitude_queue.pop_front();
                if (pitch_angle !== e.pitch) begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
                    fail_count++;
                end
                if (roll_angle !== e.roll) begin
                    $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
                    fail_count++;
                end
                if (yaw_angle !== e.yaw) begin
                    $error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
                    fail_count++;
                end
            end
        end
    end

    // draw a wait per result; count it down only while a result is offered
    initial begin
        int gap;
        gap = $urandom_range(0, 18);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                gap = $urandom_range(0, 18);
            end else if (out_valid && gap > 0) begin
                gap--;
            end
            out_ready <= (gap == 0);
        end
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        blend_w = BLEND_RESET;
        dt = STEP_RESET;
        drift = DRIFT_RESET;
        pitch_q = 0;
        roll_q = 0;
        yaw_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_directed();
        test_saturation_extremes();
        test_zero_weight_zero_step();
        test_random_phase(400, 1'b0);
        for (int p = 0; p < 3; p++)
            test_random_phase(400, 1'b1);

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && attitude_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/imu_cf_pkg.sv
hdl/imu_complementary_filter.sv
test/tb_imu_complementary_filter.sv
